### rtl/tht_pkg.sv
// ----------------------------------------------------------------------------
// tht_pkg
// Shared types and constants for the binary image thinning core.
// ----------------------------------------------------------------------------
`default_nettype none

package tht_pkg;

	// row word and row store geometry
	localparam int ROW_BITS  = 64;
	localparam int ROW_SLOTS = 64;
	localparam int ROW_AW    = 6;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LIMEN  = 2'd2,
		REG_LIMIT  = 2'd3
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ITER,
		ST_PRIME,
		ST_FILL,
		ST_RUN,
		ST_PEND,
		ST_ERD,
		ST_EMIT
	} state_t;

	// 3x3 neighborhood of one pixel, bit 0 = left column, bit 2 = right column
	typedef struct packed {
		logic [2:0] up;
		logic [2:0] mid;
		logic [2:0] dn;
	} win_t;

endpackage

`default_nettype wire

### rtl/tht_lane.sv
// ----------------------------------------------------------------------------
// tht_lane
// Deletion test for one pixel column over a 3x3 neighborhood.
// ----------------------------------------------------------------------------
`default_nettype none

module tht_lane (
	input  tht_pkg::win_t win,
	input  logic          second,
	output logic          del
);
	import tht_pkg::*;

	logic [7:0] nb;
	logic [7:0] rise;
	logic [3:0] sum;
	logic [3:0] trans;
	logic       prod_ok;

	// neighbors p2..p9 clockwise from the top
	assign nb[0] = win.up[1];
	assign nb[1] = win.up[2];
	assign nb[2] = win.mid[2];
	assign nb[3] = win.dn[2];
	assign nb[4] = win.dn[1];
	assign nb[5] = win.dn[0];
	assign nb[6] = win.mid[0];
	assign nb[7] = win.up[0];

	// 0-to-1 transitions walking around the ring
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			rise[k] = !nb[k] && nb[(k + 1) % 8];
		end
	end

	assign sum   = 4'($countones(nb));
	assign trans = 4'($countones(rise));

	// subpass specific products
	always_comb begin
		if (!second) begin
			prod_ok = !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
		end else begin
			prod_ok = !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
		end
	end

	assign del = win.mid[1] && (sum >= 4'd2) && (sum <= 4'd6) && (trans == 4'd1) && prod_ok;

endmodule

`default_nettype wire

### rtl/tht_lanes.sv
// ----------------------------------------------------------------------------
// tht_lanes
// One lane per column tests a whole row at once; the merge clears the
// marked pixels and reports whether any pixel of the row was deleted.
// ----------------------------------------------------------------------------
`default_nettype none

module tht_lanes (
	input  logic [tht_pkg::ROW_BITS-1:0] up_row,
	input  logic [tht_pkg::ROW_BITS-1:0] cur_row,
	input  logic [tht_pkg::ROW_BITS-1:0] dn_row,
	input  logic                         second,
	output logic [tht_pkg::ROW_BITS-1:0] new_row,
	output logic                         any_del
);
	import tht_pkg::*;

	logic [ROW_BITS+1:0] up_ext;
	logic [ROW_BITS+1:0] cur_ext;
	logic [ROW_BITS+1:0] dn_ext;
	logic [ROW_BITS-1:0] del;

	// zero columns outside the row
	assign up_ext  = {1'b0, up_row, 1'b0};
	assign cur_ext = {1'b0, cur_row, 1'b0};
	assign dn_ext  = {1'b0, dn_row, 1'b0};

	// column lanes
	for (genvar j = 0; j < ROW_BITS; j++) begin : g_lane
		win_t win;
		assign win.up  = up_ext[j+2:j];
		assign win.mid = cur_ext[j+2:j];
		assign win.dn  = dn_ext[j+2:j];
		tht_lane u_lane (
			.win    (win),
			.second (second),
			.del    (del[j])
		);
	end

	// merge lane results
	assign new_row = cur_row & ~del;
	assign any_del = |del;

endmodule

`default_nettype wire

### rtl/binary_image_thinning_core.sv
// ----------------------------------------------------------------------------
// binary_image_thinning_core
// Loads a binary image row by row, thins it with two alternating subpasses
// and emits the thinned rows.
// ----------------------------------------------------------------------------
// usage:
//   a request (start high while busy is low) loads one 64-bit row. the image
//   completes on final_row or when the configured height is reached; busy
//   then rises and stays high through thinning and emission.
//   each subpass streams the row store once through 64 column lanes, one
//   row per cycle; the single read port of the row store sets this pace.
//   emission puts out one row per cycle on thinned_row with result_valid
//   high for exactly one cycle per row, last_of_image on the final row. the
//   receiver cannot stall, so emission never waits. configuration writes
//   (cfg_we) take effect at once and must be made while busy is low; the
//   block does not enforce this. reset returns to loading with an empty
//   image and the register reset values; the row store keeps no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_image_thinning_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [tht_pkg::ROW_BITS-1:0] row_pixels,
	input  logic                         final_row,
	output logic                         result_valid,
	output logic [tht_pkg::ROW_BITS-1:0] thinned_row,
	output logic [5:0]                   row_number,
	output logic                         last_of_image
);
	import tht_pkg::*;

	localparam logic [6:0] HCAP = 7'((MAX_HEIGHT < ROW_SLOTS) ? MAX_HEIGHT : ROW_SLOTS);
	localparam logic [6:0] WCAP = 7'((MAX_WIDTH < ROW_BITS) ? MAX_WIDTH : ROW_BITS);

	// configuration registers
	logic [6:0]  width_q;
	logic [6:0]  height_q;
	logic        limen_q;
	logic [15:0] limit_q;

	// control
	state_t      state_q, state_d;
	logic [6:0]  rows_q;
	logic [15:0] iter_q;
	logic [ROW_AW-1:0] idx_q;
	logic        second_q;
	logic        any_q;

	// datapath
	logic [ROW_BITS-1:0] mem [ROW_SLOTS];
	logic [ROW_BITS-1:0] rd_q;
	logic [ROW_BITS-1:0] up_q;
	logic [ROW_BITS-1:0] cur_q;
	logic [ROW_BITS-1:0] wmask_q;
	logic [6:0]          n_q;

	logic [6:0]          eff_h;
	logic [6:0]          eff_w;
	logic [ROW_BITS-1:0] wmask_d;
	logic [6:0]          rows_inc;
	logic                do_store;
	logic [6:0]          rows_after;
	logic                accept;
	logic                complete;
	logic [6:0]          idx_inc;
	logic                idx_last;
	logic [ROW_BITS-1:0] rd_masked;
	logic [ROW_BITS-1:0] dn_row;
	logic [ROW_BITS-1:0] new_row;
	logic                any_del;
	logic                limit_hit;

	logic                mem_we;
	logic [ROW_AW-1:0]   mem_waddr;
	logic [ROW_BITS-1:0] mem_wdata;
	logic [ROW_AW-1:0]   rd_addr;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			limen_q  <= 1'b0;
			limit_q  <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[6:0];
				REG_HEIGHT: height_q <= cfg_data[6:0];
				REG_LIMEN:  limen_q  <= cfg_data[0];
				REG_LIMIT:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective geometry
	always_comb begin
		eff_h = height_q;
		if (eff_h == 7'd0) eff_h = 7'd1;
		if (eff_h > HCAP) eff_h = HCAP;
		eff_w = width_q;
		if (eff_w == 7'd0) eff_w = 7'd1;
		if (eff_w > WCAP) eff_w = WCAP;
		if (eff_w >= 7'(ROW_BITS)) begin
			wmask_d = '1;
		end else begin
			wmask_d = (ROW_BITS'(1) << eff_w) - ROW_BITS'(1);
		end
	end

	// load bookkeeping
	assign accept     = start && (state_q == ST_LOAD);
	assign rows_inc   = rows_q + 7'd1;
	assign do_store   = rows_q < eff_h;
	assign rows_after = do_store ? rows_inc : rows_q;
	assign complete   = final_row || (rows_after >= eff_h);

	assign idx_inc   = {1'b0, idx_q} + 7'd1;
	assign idx_last  = idx_inc == n_q;
	assign rd_masked = rd_q & wmask_q;
	assign dn_row    = idx_last ? '0 : rd_masked;
	assign limit_hit = limen_q && (iter_q >= limit_q);

	// column lanes and merge
	tht_lanes u_lanes (
		.up_row  (up_q),
		.cur_row (cur_q),
		.dn_row  (dn_row),
		.second  (second_q),
		.new_row (new_row),
		.any_del (any_del)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, store access
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = rows_q[ROW_AW-1:0];
		mem_wdata = row_pixels;
		rd_addr   = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					mem_we = do_store;
					if (complete) state_d = ST_ITER;
				end
			end
			ST_ITER: begin
				state_d = limit_hit ? ST_ERD : ST_PRIME;
			end
			ST_PRIME: begin
				state_d = ST_FILL;
			end
			ST_FILL: begin
				rd_addr = ROW_AW'(1);
				state_d = ST_RUN;
			end
			ST_RUN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = new_row;
				rd_addr   = idx_q + ROW_AW'(2);
				if (idx_last) state_d = ST_PEND;
			end
			ST_PEND: begin
				if (!any_q) begin
					state_d = ST_ERD;
				end else if (!second_q) begin
					state_d = ST_PRIME;
				end else begin
					state_d = ST_ITER;
				end
			end
			ST_ERD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				rd_addr = idx_inc[ROW_AW-1:0];
				if (idx_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// row store
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= 7'd0;
			iter_q   <= 16'd0;
			idx_q    <= '0;
			second_q <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						rows_q <= rows_after;
						iter_q <= 16'd0;
						second_q <= 1'b0;
					end
				end
				ST_ITER: begin
					second_q <= 1'b0;
					if (!limit_hit && iter_q != 16'hFFFF) iter_q <= iter_q + 16'd1;
				end
				ST_PRIME: begin
					any_q <= 1'b0;
				end
				ST_FILL: begin
					idx_q <= '0;
				end
				ST_RUN: begin
					any_q <= any_q | any_del;
					idx_q <= idx_inc[ROW_AW-1:0];
				end
				ST_PEND: begin
					second_q <= 1'b1;
				end
				ST_ERD: begin
					idx_q <= '0;
				end
				ST_EMIT: begin
					idx_q <= idx_inc[ROW_AW-1:0];
					if (idx_last) rows_q <= 7'd0;
				end
				default: ;
			endcase
		end
	end

	// row window and image geometry
	always_ff @(posedge clk) begin
		if (accept && complete) begin
			n_q     <= (rows_after < eff_h) ? rows_after : eff_h;
			wmask_q <= wmask_d;
		end
		if (state_q == ST_FILL) begin
			up_q  <= '0;
			cur_q <= rd_masked;
		end else if (state_q == ST_RUN) begin
			up_q  <= cur_q;
			cur_q <= dn_row;
		end
	end

	// result port
	assign busy          = state_q != ST_LOAD;
	assign result_valid  = state_q == ST_EMIT;
	assign thinned_row   = rd_masked;
	assign row_number    = idx_q;
	assign last_of_image = idx_last;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_image_thinning_core. Rows are loaded as
// start/busy requests, images are completed by final_row or by the height
// setting, and every emitted row is compared against a bit-true thinning
// predictor in the bench or a known row of the table. A directed table runs
// first, then random images of varied size, shape and iteration limit.
// ----------------------------------------------------------------------------

module tb;
	import tht_pkg::*;

	localparam int MAX_W      = 64;
	localparam int MAX_H      = 64;
	localparam int GAP_MAX    = 12;
	localparam int IDLE_PAD   = 4;
	localparam int RAND_ITEMS = 100;
	localparam logic [63:0] ONES = {64{1'b1}};

	typedef struct {
		logic [63:0] row;
		logic [5:0]  num;
		logic        last;
	} thin_result_t;

	typedef enum {OP_CFG, OP_ROW} dir_op_t;

	typedef struct {
		dir_op_t     op;
		cfg_reg_t    idx;
		logic [15:0] val;
		logic [63:0] row;
		bit          fin;
		bit          known;
		logic [63:0] want;
	} dir_item_t;

	typedef enum {PAT_NOISE, PAT_BLOB, PAT_HOLES, PAT_SPECKLE} pattern_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = REG_WIDTH;
	logic [15:0] cfg_data      = 16'd0;
	logic        start         = 1'b0;
	logic [63:0] row_pixels    = 64'd0;
	logic        final_row     = 1'b0;
	logic        busy;
	logic        result_valid;
	logic [63:0] thinned_row;
	logic [5:0]  row_number;
	logic        last_of_image;

	// predictor state and register copies
	logic [63:0]  img_store [MAX_H];
	int           rows_loaded;
	int           cur_width;
	int           cur_height;
	bit           cur_lim_en;
	int           cur_limit;
	thin_result_t pending_rows [$];
	dir_item_t    dir_tab [$];
	int           err_count;
	bit           no_gap;

	binary_image_thinning_core #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.row_pixels   (row_pixels),
		.final_row    (final_row),
		.result_valid (result_valid),
		.thinned_row  (thinned_row),
		.row_number   (row_number),
		.last_of_image(last_of_image)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	// effective geometry after clamping
	function automatic int eff_w();
		int w;
		w = cur_width;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int eff_h();
		int h;
		h = cur_height;
		if (h < 1) h = 1;
		if (h > MAX_H) h = MAX_H;
		return h;
	endfunction

	function automatic logic [63:0] low_mask(int w);
		return (w >= 64) ? ONES : ((64'd1 << w) - 64'd1);
	endfunction

	// pixel read, zero outside the image
	function automatic bit pix(int i, int j, int n, int w);
		if (i < 0 || j < 0 || i >= n || j >= w) return 1'b0;
		return img_store[i][j];
	endfunction

	// one subpass over the image, all deletions applied together
	function automatic bit thin_subpass(bit second, int n, int w);
		logic [63:0] mark [MAX_H];
		bit          nb [8];
		bit          any;
		bit          del;
		int          sum;
		int          trans;
		int          i;
		int          j;
		int          k;
		any = 1'b0;
		for (i = 0; i < n; i++) begin
			mark[i] = 64'd0;
			for (j = 0; j < w; j++) begin
				if (pix(i, j, n, w)) begin
					nb[0] = pix(i - 1, j,     n, w);
					nb[1] = pix(i - 1, j + 1, n, w);
					nb[2] = pix(i,     j + 1, n, w);
					nb[3] = pix(i + 1, j + 1, n, w);
					nb[4] = pix(i + 1, j,     n, w);
					nb[5] = pix(i + 1, j - 1, n, w);
					nb[6] = pix(i,     j - 1, n, w);
					nb[7] = pix(i - 1, j - 1, n, w);
					sum = 0;
					trans = 0;
					for (k = 0; k < 8; k++) begin
						sum += int'(nb[k]);
						if (!nb[k] && nb[(k + 1) % 8]) trans++;
					end
					del = (sum >= 2) && (sum <= 6) && (trans == 1);
					if (!second)
						del = del && !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
					else
						del = del && !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
					if (del) begin
						mark[i][j] = 1'b1;
						any = 1'b1;
					end
				end
			end
		end
		for (i = 0; i < n; i++) img_store[i] &= ~mark[i];
		return any;
	endfunction

	// alternate subpasses until nothing changes or the limit is hit
	function automatic void thin_image(int n, int w);
		int iters;
		bit running;
		iters = 0;
		running = 1'b1;
		while (running) begin
			if (cur_lim_en && iters >= cur_limit) begin
				running = 1'b0;
			end else begin
				if (iters < 16'hFFFF) iters++;
				if (!thin_subpass(1'b0, n, w)) running = 1'b0;
				else if (!thin_subpass(1'b1, n, w)) running = 1'b0;
			end
		end
	endfunction

	// store one accepted row; on image completion queue the thinned rows
	function automatic void load_row(logic [63:0] row, bit fin, bit known,
		logic [63:0] want);
		thin_result_t res;
		logic [63:0]  wmask;
		int           h;
		int           n;
		int           w;
		int           i;
		h = eff_h();
		if (rows_loaded < h) begin
			img_store[rows_loaded] = row;
			rows_loaded++;
		end
		if (fin || rows_loaded >= h) begin
			n = (rows_loaded < h) ? rows_loaded : h;
			w = eff_w();
			wmask = low_mask(w);
			for (i = 0; i < n; i++) img_store[i] &= wmask;
			thin_image(n, w);
			for (i = 0; i < n; i++) begin
				res.row  = known ? want : img_store[i];
				res.num  = i[5:0];
				res.last = (i == n - 1);
				pending_rows.insert(pending_rows.size(), res);
			end
			rows_loaded = 0;
		end
	endfunction

	// hold off requests until every queued row has come out
	task automatic drain();
		start <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	// register write, only while the core is idle
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH:  cur_width  = int'(val[6:0]);
			REG_HEIGHT: cur_height = int'(val[6:0]);
			REG_LIMEN:  cur_lim_en = val[0];
			REG_LIMIT:  cur_limit  = int'(val);
			default:    ;
		endcase
		cfg_we <= 1'b0;
	endtask

	// one row request; start stays high when the next one follows at once
	task automatic send_row(logic [63:0] row, bit fin, bit known, logic [63:0] want);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		row_pixels <= row;
		final_row  <= fin;
		do @(posedge clk); while (busy);
		load_row(row, fin, known, want);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic dir_item_t mk_cfg(cfg_reg_t idx, logic [15:0] val);
		dir_item_t d;
		d = '{OP_CFG, idx, val, 64'd0, 1'b0, 1'b0, 64'd0};
		return d;
	endfunction

	function automatic dir_item_t mk_row(logic [63:0] row, bit fin, bit known,
		logic [63:0] want);
		dir_item_t d;
		d = '{OP_ROW, REG_WIDTH, 16'd0, row, fin, known, want};
		return d;
	endfunction

	// append one row of the directed table
	function automatic void tab_add(dir_item_t d);
		dir_tab.insert(dir_tab.size(), d);
	endfunction

	// result checker
	always @(posedge clk) begin : result_check
		thin_result_t want;
		if (arst_n && result_valid) begin
			if (pending_rows.size() == 0) begin
				report_mismatch($sformatf("unexpected row %0d", row_number));
			end else begin
				want = pending_rows.pop_front();
				if (thinned_row !== want.row)
					report_mismatch($sformatf("row %0d pixels %h, want %h",
						want.num, thinned_row, want.row));
				if (row_number !== want.num)
					report_mismatch($sformatf("row number %0d, want %0d",
						row_number, want.num));
				if (last_of_image !== want.last)
					report_mismatch($sformatf("row %0d last flag %b, want %b",
						want.num, last_of_image, want.last));
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [63:0] row;
		logic [63:0] wmask;
		logic [63:0] blob;
		pattern_t    pat;
		bit          junk;
		bit          fin;
		int          rand_items;
		int          img_no;
		int          pick;
		int          mode;
		int          nr;
		int          r;
		int          r0;
		int          r1;
		int          c0;
		int          c1;
		int          w;
		int          h;
		int          k;

		rows_loaded = 0;
		cur_width   = 64;
		cur_height  = 64;
		cur_lim_en  = 1'b0;
		cur_limit   = 0;
		err_count   = 0;
		no_gap      = 1'b0;
		for (k = 0; k < MAX_H; k++) img_store[k] = 64'd0;

		// single-row images never lose pixels, so their output reads off the input
		tab_add(mk_row(ONES, 1'b1, 1'b1, ONES));
		tab_add(mk_row(64'd0, 1'b1, 1'b1, 64'd0));
		// width below range counts as one column
		tab_add(mk_cfg(REG_WIDTH, 16'd0));
		tab_add(mk_row(ONES, 1'b1, 1'b1, 64'd1));
		// width above range counts as full width
		tab_add(mk_cfg(REG_WIDTH, 16'd100));
		tab_add(mk_row(64'hA5A5_5A5A_F00F_0FF0, 1'b1, 1'b1,
			64'hA5A5_5A5A_F00F_0FF0));
		// solid block completing on height
		tab_add(mk_cfg(REG_WIDTH, 16'd9));
		tab_add(mk_cfg(REG_HEIGHT, 16'd3));
		for (k = 0; k < 3; k++) tab_add(mk_row(64'h1FF, 1'b0, 1'b0, 64'd0));
		// height zero counts as one row, bits above width dropped
		tab_add(mk_cfg(REG_HEIGHT, 16'd0));
		tab_add(mk_row(64'hFFFF, 1'b0, 1'b1, 64'h1FF));
		// height above range, image closed early by final_row
		tab_add(mk_cfg(REG_HEIGHT, 16'd127));
		tab_add(mk_cfg(REG_WIDTH, 16'd64));
		tab_add(mk_row(64'h8000_0000_0000_0007, 1'b0, 1'b0, 64'd0));
		tab_add(mk_row(64'hC000_0000_0000_000F, 1'b0, 1'b0, 64'd0));
		tab_add(mk_row(64'hE000_0000_0000_001E, 1'b0, 1'b0, 64'd0));
		tab_add(mk_row(64'hF000_0000_0000_003C, 1'b0, 1'b0, 64'd0));
		tab_add(mk_row(64'hF800_0000_0000_0078, 1'b1, 1'b0, 64'd0));
		// zero iteration limit leaves the image untouched
		tab_add(mk_cfg(REG_LIMEN, 16'd1));
		tab_add(mk_cfg(REG_LIMIT, 16'd0));
		tab_add(mk_cfg(REG_HEIGHT, 16'd3));
		tab_add(mk_cfg(REG_WIDTH, 16'd9));
		for (k = 0; k < 3; k++) tab_add(mk_row(64'h1FF, 1'b0, 1'b0, 64'd0));
		// single iteration
		tab_add(mk_cfg(REG_LIMIT, 16'd1));
		for (k = 0; k < 3; k++) tab_add(mk_row(64'h1FF, 1'b0, 1'b0, 64'd0));
		// height lowered under the loaded count drops the next row
		tab_add(mk_cfg(REG_LIMIT, 16'hFFFF));
		tab_add(mk_cfg(REG_HEIGHT, 16'd6));
		for (k = 0; k < 4; k++) tab_add(mk_row(64'h3F, 1'b0, 1'b0, 64'd0));
		tab_add(mk_cfg(REG_HEIGHT, 16'd2));
		tab_add(mk_row(64'hFFFF, 1'b0, 1'b0, 64'd0));
		tab_add(mk_cfg(REG_LIMEN, 16'd0));

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[k]) begin
			if (dir_tab[k].op == OP_CFG)
				write_reg(dir_tab[k].idx, dir_tab[k].val);
			else
				send_row(dir_tab[k].row, dir_tab[k].fin, dir_tab[k].known, dir_tab[k].want);
		end

		// random images
		rand_items = 0;
		img_no = 0;
		while (rand_items < RAND_ITEMS) begin
			no_gap = ($urandom_range(0, 3) == 0);

			// new settings, or a full pause between images
			if (img_no == 0 || $urandom_range(0, 2) == 0) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) write_reg(REG_WIDTH, 16'($urandom_range(0, 127)));
				else if (pick < 3) write_reg(REG_WIDTH, 16'd64);
				else write_reg(REG_WIDTH, 16'($urandom_range(1, 20)));
				pick = $urandom_range(0, 11);
				if (pick == 0 && rand_items < RAND_ITEMS / 2) write_reg(REG_HEIGHT, 16'd64);
				else if (pick == 1) write_reg(REG_HEIGHT, 16'd0);
				else write_reg(REG_HEIGHT, 16'($urandom_range(1, 12)));
				write_reg(REG_LIMEN, 16'($urandom_range(0, 3) == 0));
				pick = $urandom_range(0, 5);
				if (pick == 0) write_reg(REG_LIMIT, 16'd0);
				else if (pick == 1) write_reg(REG_LIMIT, 16'hFFFF);
				else if (pick == 2) write_reg(REG_LIMIT, 16'($urandom_range(0, 65535)));
				else write_reg(REG_LIMIT, 16'($urandom_range(1, 4)));
			end else if (img_no == 1 || $urandom_range(0, 4) == 0) begin
				drain();
			end

			w = eff_w();
			h = eff_h();
			wmask = low_mask(w);
			r0 = $urandom_range(0, h - 1);
			r1 = $urandom_range(r0, h - 1);
			c0 = $urandom_range(0, w - 1);
			c1 = $urandom_range(c0, w - 1);
			blob = low_mask(c1 + 1) & ~low_mask(c0);
			pat = pattern_t'($urandom_range(0, 3));
			junk = 1'($urandom_range(0, 1));
			mode = $urandom_range(0, 9);

			if (mode < 6) nr = (h > rows_loaded) ? h - rows_loaded : 1;
			else nr = $urandom_range(1, h);

			for (r = 0; r < nr; r++) begin
				case (pat)
					PAT_NOISE:   row = rand_word();
					PAT_BLOB:    row = (r >= r0 && r <= r1) ? blob : 64'd0;
					PAT_HOLES:   row = ((r >= r0 && r <= r1) ? blob : 64'd0) &
						(rand_word() | rand_word());
					default:     row = ((r >= r0 && r <= r1) ? blob : 64'd0) |
						(rand_word() & rand_word() & rand_word() & wmask);
				endcase
				if (junk) row |= rand_word() & ~wmask;
				if (r != nr - 1) fin = (mode == 9) ? ($urandom_range(0, 5) == 0) : 1'b0;
				else if (mode < 6) fin = 1'($urandom_range(0, 1));
				else if (mode < 8) fin = 1'b1;
				else if (mode == 8) fin = 1'b0;
				else fin = 1'($urandom_range(0, 1));
				send_row(row, fin, 1'b0, 64'd0);
				rand_items++;
			end

			// broken load: height dropped to at most the rows already in
			if (mode == 8 && rows_loaded > 0) begin
				write_reg(REG_HEIGHT, 16'($urandom_range(1, rows_loaded)));
				if ($urandom_range(0, 1)) write_reg(REG_WIDTH, 16'($urandom_range(1, 64)));
				send_row(rand_word(), 1'($urandom_range(0, 1)), 1'b0, 64'd0);
				rand_items++;
			end
			img_no++;
		end

		// flush a partial image left by the random loop so nothing is left loaded
		if (rows_loaded > 0) send_row(rand_word(), 1'b1, 1'b0, 64'd0);

		drain();
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending_rows.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### binary_image_thinning_core.f
rtl/tht_pkg.sv
rtl/tht_lane.sv
rtl/tht_lanes.sv
rtl/binary_image_thinning_core.sv
dv/tb.sv
